FILE: design/skpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpq_pkg
// Shared types and constants for the sorted key priority queue.
// ----------------------------------------------------------------------------
package skpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int ACT_W        = 3;
    localparam int STAT_W       = 2;
    localparam int OCC_W        = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_PREPEND    = 3'd0,
        ACT_APPEND     = 3'd1,
        ACT_REMOVE_HD  = 3'd2,
        ACT_SORTED_INS = 3'd3,
        ACT_REMOVE_KEY = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        HIT_ALL     = 2'd0,
        HIT_FREE    = 2'd1,
        HIT_GREATER = 2'd2,
        HIT_MATCH   = 2'd3
    } t_hit_mode;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic             apply;
        logic             ins;
        t_hit_mode        mode;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_cell_cmd;

endpackage

FILE: design/skpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skpq_cell
// One queue slot: holds an entry, flags a hit and shifts with its neighbors.
// ----------------------------------------------------------------------------
module skpq_cell #(
    parameter int CAPACITY = skpq_pkg::CAPACITY_DEF,
    parameter int IDX      = 0,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  skpq_pkg::t_cell_cmd  i_cmd,
    input  logic [CNT_W-1:0]     i_count,
    input  skpq_pkg::t_entry     i_left,
    input  skpq_pkg::t_entry     i_right,
    input  logic                 i_prior,
    output logic                 o_chain,
    output skpq_pkg::t_entry     o_entry,
    output skpq_pkg::t_entry     o_sel,
    output logic [skpq_pkg::KEY_W-1:0] o_tail_key
);

    skpq_pkg::t_entry r_entry;
    logic             w_occ;
    logic             w_tail;
    logic             w_hit;
    logic             w_first;

    assign w_occ  = CNT_W'(IDX) < i_count;
    assign w_tail = CNT_W'(IDX + 1) == i_count;

    always_comb begin
        case (i_cmd.mode)
            skpq_pkg::HIT_ALL:     w_hit = 1'b1;
            skpq_pkg::HIT_FREE:    w_hit = !w_occ;
            skpq_pkg::HIT_GREATER: w_hit = !w_occ ||
                                   ($signed(i_cmd.key) < $signed(r_entry.key));
            skpq_pkg::HIT_MATCH:   w_hit = w_occ && (r_entry.key == i_cmd.key);
            default:               w_hit = 1'b0;
        endcase
    end

    assign w_first    = w_hit && !i_prior;
    assign o_chain    = i_prior || w_hit;
    assign o_entry    = r_entry;
    assign o_sel      = w_first ? r_entry : '0;
    assign o_tail_key = w_tail ? r_entry.key : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (i_cmd.ins) begin
                if (i_prior) begin
                    r_entry <= i_left;
                end else if (w_hit) begin
                    r_entry.key     <= i_cmd.key;
                    r_entry.payload <= i_cmd.payload;
                end
            end else if (i_prior || w_hit) begin
                r_entry <= i_right;
            end
        end
    end

endmodule

FILE: design/sorted_key_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_priority_queue
// Bounded key/payload queue, in ascending signed key order unless keys wrap.
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, head in cell 0. In every action
// (prepend, append, remove head, sorted insert, remove by key) each cell
// flags a hit, a hit chain runs down the row to find the first hit, and the
// cells from that hit on shift left or right together. One transaction is
// accepted per cycle unless the output stalls; its response appears in the
// output register on the next cycle. The hit chain across the row sets the
// critical path. Storage has no reset; only occupied slots are ever read.
module sorted_key_priority_queue #(
    parameter int CAPACITY = skpq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // in_key[31:0], in_payload[63:32]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_payload[31:0], out_key[63:32],
                                   // occupancy[68:64], zero[71:69]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = skpq_pkg::KEY_W;
    localparam int PW    = skpq_pkg::PAY_W;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_m_valid;
    logic [PW-1:0]        r_out_payload;
    logic [KW-1:0]        r_out_key;
    skpq_pkg::t_status    r_status;
    logic [CNT_W-1:0]     r_occ;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    skpq_pkg::t_action    w_action;
    logic [KW-1:0]        w_in_key;
    logic [PW-1:0]        w_in_payload;
    skpq_pkg::t_cell_cmd  w_cmd;
    logic [PW-1:0]        w_out_payload;
    logic [KW-1:0]        w_out_key;
    skpq_pkg::t_status    w_status;
    logic [KW-1:0]        w_tail_key;
    skpq_pkg::t_entry     w_sel;

    skpq_pkg::t_entry     w_entry [CAPACITY];
    skpq_pkg::t_entry     w_cell_sel [CAPACITY];
    logic [KW-1:0]        w_cell_tail [CAPACITY];
    logic [CAPACITY:0]    w_chain;

    assign s_tready     = !r_m_valid || m_tready;
    assign w_accept     = s_tvalid && s_tready;
    assign w_action     = skpq_pkg::t_action'(s_tuser);
    assign w_in_key     = s_tdata[31:0];
    assign w_in_payload = s_tdata[63:32];
    assign w_full       = r_count == CNT_W'(CAPACITY);
    assign w_empty      = r_count == '0;
    assign w_chain[0]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            skpq_pkg::t_entry w_left;
            skpq_pkg::t_entry w_right;
            if (g == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            skpq_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g),
                .CNT_W    (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_count    (r_count),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_prior    (w_chain[g]),
                .o_chain    (w_chain[g+1]),
                .o_entry    (w_entry[g]),
                .o_sel      (w_cell_sel[g]),
                .o_tail_key (w_cell_tail[g])
            );
        end
    endgenerate

    always_comb begin
        w_sel      = '0;
        w_tail_key = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_sel      = w_sel | w_cell_sel[i];
            w_tail_key = w_tail_key | w_cell_tail[i];
        end
    end

    // removes without a hit shift nothing; shifting an empty row is harmless
    always_comb begin
        w_cmd         = '0;
        w_cmd.payload = w_in_payload;
        w_cmd.key     = w_in_key;
        case (w_action)
            skpq_pkg::ACT_PREPEND: begin
                w_cmd.ins   = 1'b1;
                w_cmd.mode  = skpq_pkg::HIT_ALL;
                w_cmd.key   = w_empty ? '0 : w_entry[0].key - KW'(1);
                w_cmd.apply = w_accept && !w_full;
            end
            skpq_pkg::ACT_APPEND: begin
                w_cmd.ins   = 1'b1;
                w_cmd.mode  = skpq_pkg::HIT_FREE;
                w_cmd.key   = w_empty ? '0 : w_tail_key + KW'(1);
                w_cmd.apply = w_accept && !w_full;
            end
            skpq_pkg::ACT_SORTED_INS: begin
                w_cmd.ins   = 1'b1;
                w_cmd.mode  = skpq_pkg::HIT_GREATER;
                w_cmd.apply = w_accept && !w_full;
            end
            skpq_pkg::ACT_REMOVE_HD: begin
                w_cmd.mode  = skpq_pkg::HIT_ALL;
                w_cmd.apply = w_accept;
            end
            skpq_pkg::ACT_REMOVE_KEY: begin
                w_cmd.mode  = skpq_pkg::HIT_MATCH;
                w_cmd.apply = w_accept;
            end
            default: begin
                w_cmd.mode = skpq_pkg::HIT_ALL;
            end
        endcase
    end

    always_comb begin
        w_out_payload = '0;
        w_out_key     = '0;
        w_status      = skpq_pkg::ST_DONE;
        n_count       = r_count;
        case (w_action)
            skpq_pkg::ACT_PREPEND, skpq_pkg::ACT_APPEND, skpq_pkg::ACT_SORTED_INS: begin
                if (w_full) begin
                    w_status = skpq_pkg::ST_FULL;
                end else begin
                    w_out_key = w_cmd.key;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            skpq_pkg::ACT_REMOVE_HD, skpq_pkg::ACT_REMOVE_KEY: begin
                if (w_empty || !w_chain[CAPACITY]) begin
                    w_status = skpq_pkg::ST_MISS;
                end else begin
                    w_out_key     = w_sel.key;
                    w_out_payload = w_sel.payload;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_payload <= w_out_payload;
            r_out_key     <= w_out_key;
            r_status      <= w_status;
            r_occ         <= n_count;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {3'b000, skpq_pkg::OCC_W'(r_occ), r_out_key, r_out_payload};
    assign m_tuser  = r_status;

endmodule

FILE: verif/tb_sorted_key_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_priority_queue
// Self-checking bench for the sorted key priority queue.
// ----------------------------------------------------------------------------
// A scripted sequence covers the empty and full queue, both key extremes,
// wrapped keys, equal keys, missing keys and the unused action codes. It is
// followed by random traffic that swings between filling and draining the
// queue. Every response is compared field by field with a scripted reply
// or a bench shadow queue. Sender gaps and receiver stalls vary by phase,
// and one phase holds the receiver off long enough to back up the input.
module tb_sorted_key_priority_queue;
    import skpq_pkg::*;

    localparam int QCAP           = CAPACITY_DEF;
    localparam int N_RANDOM       = 750;
    localparam int N_PHASES       = 6;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_NS     = 5_000_000;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // codes the block ignores
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_reply;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        bit               typed;
        t_reply           reply;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // in_key[31:0], in_payload[63:32]
    logic [2:0]  s_tuser;   // action[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // out_payload[31:0], out_key[63:32], occupancy[68:64]
    logic [1:0]  m_tuser;   // status[1:0]

    // shadow queue, head at index 0
    logic [KEY_W-1:0] shadow_keys [QCAP];
    logic [PAY_W-1:0] shadow_pays [QCAP];
    int               shadow_count;

    t_reply      replies_due [$];
    t_script_row script [$];
    logic [ACT_W-1:0] rsvd_acts [3] = '{ACT_RSVD_A, ACT_RSVD_B, ACT_RSVD_C};

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_left   = 0;
    bit hold_request   = 1'b0;
    bit filling        = 1'b1;

    sorted_key_priority_queue #(
        .CAPACITY (QCAP)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void unlink_entry(input int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_pays[i] = shadow_pays[i + 1];
        end
        shadow_count--;
    endfunction

    // applies one action to the shadow queue and returns its response
    function automatic t_reply apply_queue_action(input logic [ACT_W-1:0] act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] pay);
        t_reply           r;
        int               pos;
        bit               is_insert;
        logic [KEY_W-1:0] new_key;
        r         = '0;
        r.status  = ST_DONE;
        is_insert = 1'b0;
        pos       = 0;
        new_key   = key;
        case (act)
            ACT_PREPEND: begin
                is_insert = 1'b1;
                pos       = 0;
                new_key   = (shadow_count == 0) ? '0 : shadow_keys[0] - 1;
            end
            ACT_APPEND: begin
                is_insert = 1'b1;
                pos       = shadow_count;
                new_key   = (shadow_count == 0) ? '0 : shadow_keys[shadow_count - 1] + 1;
            end
            ACT_SORTED_INS: begin
                is_insert = 1'b1;
                pos       = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--) begin
                    if ($signed(key) < $signed(shadow_keys[i])) pos = i;
                end
            end
            ACT_REMOVE_HD: begin
                if (shadow_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.key     = shadow_keys[0];
                    r.payload = shadow_pays[0];
                    unlink_entry(0);
                end
            end
            ACT_REMOVE_KEY: begin
                pos = -1;
                for (int i = shadow_count - 1; i >= 0; i--) begin
                    if (shadow_keys[i] == key) pos = i;
                end
                if (pos < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.key     = shadow_keys[pos];
                    r.payload = shadow_pays[pos];
                    unlink_entry(pos);
                end
            end
            default: ;
        endcase
        if (is_insert) begin
            if (shadow_count >= QCAP) begin
                r.status = ST_FULL;
            end else begin
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i - 1];
                    shadow_pays[i] = shadow_pays[i - 1];
                end
                shadow_keys[pos] = new_key;
                shadow_pays[pos] = pay;
                shadow_count++;
                r.key = new_key;
            end
        end
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    function automatic t_script_row script_row(input logic [ACT_W-1:0] act,
                                               input logic [KEY_W-1:0] key,
                                               input logic [PAY_W-1:0] pay,
                                               input bit               typed,
                                               input logic [PAY_W-1:0] e_pay,
                                               input logic [KEY_W-1:0] e_key,
                                               input t_status          e_st,
                                               input logic [OCC_W-1:0] e_occ);
        t_script_row row;
        row.act             = act;
        row.key             = key;
        row.payload         = pay;
        row.typed           = typed;
        row.reply.payload   = e_pay;
        row.reply.key       = e_key;
        row.reply.status    = e_st;
        row.reply.occupancy = e_occ;
        return row;
    endfunction

    // keys already queued when a hit is wanted, otherwise extremes, neighbors or anything
    function automatic logic [KEY_W-1:0] pick_key(input bit want_hit);
        logic [KEY_W-1:0] k;
        if (want_hit && shadow_count > 0) begin
            k = shadow_keys[$urandom_range(shadow_count - 1)];
        end else begin
            case ($urandom_range(5))
                0: k = KEY_MIN;
                1: k = KEY_MAX;
                2: k = '0;
                3: k = '1;
                4: k = (shadow_count > 0) ? shadow_keys[$urandom_range(shadow_count - 1)] + 1
                                          : $urandom;
                default: k = $urandom;
            endcase
        end
        return k;
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int n;
        logic [ACT_W-1:0] a;
        n = $urandom_range(99);
        if (n < 3) begin
            a = rsvd_acts[$urandom_range(2)];
        end else if (filling ? (n < 70) : (n < 30)) begin
            case ($urandom_range(2))
                0:       a = ACT_PREPEND;
                1:       a = ACT_APPEND;
                default: a = ACT_SORTED_INS;
            endcase
        end else begin
            a = $urandom_range(1) ? ACT_REMOVE_HD : ACT_REMOVE_KEY;
        end
        return a;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay, input bit typed,
                             input t_reply typed_reply);
        t_reply r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pay, key};
        s_tuser  <= act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        r = apply_queue_action(act, key, pay);
        replies_due.push_back(typed ? typed_reply : r);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected transaction, payload %h key %h status %0d occ %0d",
                         $time, m_tdata[31:0], m_tdata[63:32], m_tuser, m_tdata[68:64]);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (m_tdata[31:0] !== want.payload) begin
                    $display("%0t: payload expected %h actual %h",
                             $time, want.payload, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.key) begin
                    $display("%0t: key expected %h actual %h", $time, want.key, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[68:64] !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, m_tdata[68:64]);
                    fail_count++;
                end
                if (m_tdata[71:69] !== 3'b000) begin
                    $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[71:69]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_reply      no_reply;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        no_reply = '0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        shadow_count = 0;

        // empty queue
        script.push_back(script_row(ACT_REMOVE_HD, '0, 32'hDEAD_BEEF, 1,
                                    '0, '0, ST_MISS, 5'd0));
        script.push_back(script_row(ACT_REMOVE_KEY, '0, '0, 1, '0, '0, ST_MISS, 5'd0));
        // first keys, extremes, wrap at both ends
        script.push_back(script_row(ACT_APPEND, 32'h1357_9BDF, 32'hFFFF_FFFF, 1,
                                    '0, '0, ST_DONE, 5'd1));
        script.push_back(script_row(ACT_PREPEND, '0, '0, 1, '0, 32'hFFFF_FFFF, ST_DONE, 5'd2));
        script.push_back(script_row(ACT_SORTED_INS, KEY_MAX, 32'hA5A5_A5A5, 1,
                                    '0, KEY_MAX, ST_DONE, 5'd3));
        script.push_back(script_row(ACT_SORTED_INS, KEY_MIN, 32'h5A5A_5A5A, 1,
                                    '0, KEY_MIN, ST_DONE, 5'd4));
        script.push_back(script_row(ACT_PREPEND, '0, 32'h1234_5678, 1,
                                    '0, KEY_MAX, ST_DONE, 5'd5));
        script.push_back(script_row(ACT_APPEND, '0, 32'h8765_4321, 1,
                                    '0, KEY_MIN, ST_DONE, 5'd6));
        // insert into wrapped order, equal keys, remove by key hit and miss
        script.push_back(script_row(ACT_SORTED_INS, '0, 32'hC3C3_C3C3, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, '0, 32'h3C3C_3C3C, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_REMOVE_KEY, '0, 32'hFFFF_FFFF, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_REMOVE_KEY, 32'h0001_2345, '0, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_RSVD_A, KEY_MAX, 32'hFFFF_FFFF, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_RSVD_B, KEY_MIN, 32'h0F0F_0F0F, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_RSVD_C, '1, 32'hF0F0_F0F0, 0, '0, '0, ST_DONE, '0));
        // fill to capacity
        script.push_back(script_row(ACT_SORTED_INS, 32'h0000_0100, 32'h0000_0001, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, 32'hFFFF_FF00, 32'h0000_0002, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, KEY_MAX, 32'h0000_0003, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, KEY_MIN, 32'h0000_0004, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, 32'h0000_0100, 32'h0000_0005, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_PREPEND, '0, 32'h0000_0006, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_APPEND, '0, 32'h0000_0007, 0, '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, 32'h4000_0000, 32'h0000_0008, 0,
                                    '0, '0, ST_DONE, '0));
        script.push_back(script_row(ACT_SORTED_INS, 32'hC000_0000, 32'h0000_0009, 0,
                                    '0, '0, ST_DONE, '0));
        // full queue drops every insert kind
        script.push_back(script_row(ACT_PREPEND, '0, 32'hFFFF_FFFF, 1, '0, '0, ST_FULL, 5'd16));
        script.push_back(script_row(ACT_APPEND, '0, 32'hFFFF_FFFF, 1, '0, '0, ST_FULL, 5'd16));
        script.push_back(script_row(ACT_SORTED_INS, '0, 32'hFFFF_FFFF, 1,
                                    '0, '0, ST_FULL, 5'd16));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_item(script[i].act, script[i].key, script[i].payload,
                      script[i].typed, script[i].reply);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
                3:       begin send_idle_pct = 22; recv_stall_pct = 22; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (ph == 4) hold_request = 1'b1;
            repeat (N_RANDOM / N_PHASES) begin
                if (shadow_count == QCAP && $urandom_range(99) < 30) filling = 1'b0;
                if (shadow_count == 0 && $urandom_range(99) < 30) filling = 1'b1;
                if ($urandom_range(99) < 2) filling = !filling;
                act = pick_action();
                key = pick_key(act == ACT_REMOVE_KEY ? ($urandom_range(99) < 75)
                                                     : ($urandom_range(99) < 40));
                send_item(act, key, $urandom, 0, no_reply);
            end
        end

        s_tvalid       <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d transactions outstanding", $time, replies_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sorted_key_priority_queue.f
design/skpq_pkg.sv
design/skpq_cell.sv
design/sorted_key_priority_queue.sv
verif/tb_sorted_key_priority_queue.sv
